[sv/khvr_pkg.sv]
// ============================================================================
// khvr_pkg: shared definitions for the key-hold velocity ramp
// Field widths, register codes, reset values, FSM states and the
// fixed-point helper functions used by the ramp datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package khvr_pkg;

    // Field widths
    localparam int KEY_W      = 3;
    localparam int NKEYS      = 5;
    localparam int TIME_W     = 32;
    localparam int VEL_W      = 16;
    localparam int SPEED_W    = 16;
    localparam int STEP_W     = 14;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Serial multiplier: radix-4, two multiplier bits per cycle
    localparam int PROD_W     = VEL_W + GAIN_W;
    localparam int MUL_DIGITS = GAIN_W / 2;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

    // Square root: two radicand bits per step
    localparam int ROOT_STEPS = PROD_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int REM_W      = SPEED_W + 1;

    // Rounded gain product: (p + 2^14) >> 15 taken as ((p >> 14) + 1) >> 1
    localparam int RND_W      = PROD_W - 14;

    localparam logic [TIME_W-1:0] HOLD_MS  = 32'd200;
    localparam logic [RND_W-1:0]  DEADBAND = 18'd4;

    // Register reset values
    localparam logic [STEP_W-1:0]  RST_LINEAR_STEP    = 14'd532;
    localparam logic [STEP_W-1:0]  RST_ANGULAR_STEP   = 14'd287;
    localparam logic [GAIN_W-1:0]  RST_BRAKE_LINEAR   = 16'd1311;
    localparam logic [GAIN_W-1:0]  RST_BRAKE_ANGULAR  = 16'd328;
    localparam logic [GAIN_W-1:0]  RST_FRIC_LINEAR    = 16'd32113;
    localparam logic [GAIN_W-1:0]  RST_FRIC_ANGULAR   = 16'd31130;
    localparam logic [LIMIT_W-1:0] RST_LINEAR_LIMIT   = 15'd8192;
    localparam logic [LIMIT_W-1:0] RST_ANGULAR_LIMIT  = 15'd8192;

    typedef enum logic [KEY_W-1:0] {
        KEY_UP    = 3'd0,
        KEY_DOWN  = 3'd1,
        KEY_LEFT  = 3'd2,
        KEY_RIGHT = 3'd3,
        KEY_BRAKE = 3'd4
    } t_key;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_STEP       = 8'd0,
        REG_ANGULAR_STEP      = 8'd1,
        REG_BRAKE_GAIN_LIN    = 8'd2,
        REG_BRAKE_GAIN_ANG    = 8'd3,
        REG_FRICTION_GAIN_LIN = 8'd4,
        REG_FRICTION_GAIN_ANG = 8'd5,
        REG_LINEAR_LIMIT      = 8'd6,
        REG_ANGULAR_LIMIT     = 8'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HELD,
        S_BRAKE,
        S_BRAKE_WAIT,
        S_FRIC,
        S_FRIC_WAIT,
        S_SQ,
        S_SQ_WAIT,
        S_ROOT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [VEL_W-1:0]  mag;
        logic [GAIN_W-1:0] mult;
    } t_mul_req;

    // Magnitude of a signed velocity; -32768 maps to 32768
    function automatic logic [VEL_W-1:0] vel_mag(input logic signed [VEL_W-1:0] v);
        logic [VEL_W-1:0] u;
        u = v;
        return v[VEL_W-1] ? (~u + 16'd1) : u;
    endfunction

    // Round the gain product, zero it below the deadband, else restore sign and saturate
    function automatic logic signed [VEL_W-1:0] gain_finish(
        input logic              neg,
        input logic [PROD_W-1:0] prod
    );
        logic [RND_W:0]   rnd;
        logic [RND_W-1:0] p;
        logic [VEL_W-1:0] res;
        rnd = {1'b0, prod[PROD_W-1:14]} + 19'd1;
        p   = rnd[RND_W:1];
        if (p < DEADBAND) begin
            res = '0;
        end else if (neg) begin
            res = (p > 18'd32768) ? 16'h8000 : (~p[VEL_W-1:0] + 16'd1);
        end else begin
            res = (p > 18'd32767) ? 16'h7fff : p[VEL_W-1:0];
        end
        return $signed(res);
    endfunction

    // Step toward the held direction and clamp to +/- limit
    function automatic logic signed [VEL_W-1:0] accel_clamp(
        input logic signed [VEL_W-1:0] v,
        input logic                    up,
        input logic [STEP_W-1:0]       step,
        input logic [LIMIT_W-1:0]      limit
    );
        logic signed [VEL_W+1:0] s;
        logic signed [VEL_W+1:0] lim;
        logic signed [VEL_W+1:0] stp;
        s   = $signed({{2{v[VEL_W-1]}}, v});
        lim = $signed({3'b000, limit});
        stp = $signed({4'b0000, step});
        if (up) begin
            s = s + stp;
        end else begin
            s = s - stp;
        end
        if (s > lim) begin
            s = lim;
        end else if (s < -lim) begin
            s = -lim;
        end
        return $signed(s[VEL_W-1:0]);
    endfunction

endpackage

`default_nettype wire

[sv/khvr_if.sv]
// ============================================================================
// khvr_if: handshake channels of the key-hold velocity ramp
// Input item, result item and register write channels, valid/ready each.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface khvr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [khvr_pkg::KEY_W-1:0]   key;
    logic [khvr_pkg::TIME_W-1:0]  time_ms;

    modport source (output valid, output action, output key, output time_ms, input ready);
    modport sink   (input valid, input action, input key, input time_ms, output ready);
endinterface

interface khvr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [khvr_pkg::VEL_W-1:0]   linear_velocity;
    logic signed [khvr_pkg::VEL_W-1:0]   angular_velocity;
    logic        [khvr_pkg::SPEED_W-1:0] speed;

    modport source (output valid, output linear_velocity, output angular_velocity,
                    output speed, input ready);
    modport sink   (input valid, input linear_velocity, input angular_velocity,
                    input speed, output ready);
endinterface

interface khvr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [khvr_pkg::CFG_IDX_W-1:0]    index;
    logic [khvr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/khvr_mul.sv]
// ============================================================================
// khvr_mul: radix-4 serial multiplier
// Unsigned 16 x 16 product, two multiplier bits per cycle, LSB first.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module khvr_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  khvr_pkg::t_mul_req            i_req,
    output logic                          o_done,
    output logic [khvr_pkg::PROD_W-1:0]   o_product
);
    import khvr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [VEL_W-1:0]     r_mag;
    logic [GAIN_W-1:0]    r_mult;
    logic [VEL_W-1:0]     r_hi;
    logic [GAIN_W-1:0]    r_lo;

    logic [VEL_W+1:0]     w_pp;
    logic [VEL_W+1:0]     w_sum;

    // partial product for one radix-4 digit
    always_comb begin
        unique case (r_mult[1:0])
            2'd0:    w_pp = '0;
            2'd1:    w_pp = {2'b00, r_mag};
            2'd2:    w_pp = {1'b0, r_mag, 1'b0};
            default: w_pp = {2'b00, r_mag} + {1'b0, r_mag, 1'b0};
        endcase
    end

    assign w_sum = {2'b00, r_hi} + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag  <= i_req.mag;
            r_mult <= i_req.mult;
            r_hi   <= '0;
        end else if (r_busy) begin
            r_mult <= {2'b00, r_mult[GAIN_W-1:2]};
            r_hi   <= w_sum[VEL_W+1:2];
            r_lo   <= {w_sum[1:0], r_lo[GAIN_W-1:2]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

[sv/key_hold_velocity_ramp_unit.sv]
// ============================================================================
// key_hold_velocity_ramp_unit: key-hold velocity ramp, top level
// Press beat: recorded in S_IDLE, input ready stays high throughout.
// Update beat: two 8-digit serial multiply passes (three with brake), then a
// 16-step root; the result is registered in S_EMIT, and input ready rises as
// it turns valid, so no beat is taken before then. S_EMIT stalls on a full output.
// Sync active-low reset: registers to defaults, all keys unseen, velocities 0.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module key_hold_velocity_ramp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    khvr_in_if.sink     i_in,
    khvr_out_if.source  o_out,
    khvr_cfg_if.sink    i_cfg
);
    import khvr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]  r_lin_step;
    logic [STEP_W-1:0]  r_ang_step;
    logic [GAIN_W-1:0]  r_brk_lin;
    logic [GAIN_W-1:0]  r_brk_ang;
    logic [GAIN_W-1:0]  r_fric_lin;
    logic [GAIN_W-1:0]  r_fric_ang;
    logic [LIMIT_W-1:0] r_lin_limit;
    logic [LIMIT_W-1:0] r_ang_limit;

    // ------------------------------------------------------------------
    // Key table and ramp state
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]       r_press_time [NKEYS];
    logic [NKEYS-1:0]        r_press_seen;
    logic [TIME_W-1:0]       r_now;
    logic [NKEYS-1:0]        r_held;
    logic signed [VEL_W-1:0] r_lin;
    logic signed [VEL_W-1:0] r_ang;

    // square root unit
    logic [PROD_W-1:0]       r_rad;
    logic [REM_W-1:0]        r_rem;
    logic [SPEED_W-1:0]      r_root;
    logic [ROOT_CNT_W-1:0]   r_cnt;

    // output register, frees the input side while a result waits
    logic                    r_out_valid;
    logic signed [VEL_W-1:0] r_out_lin;
    logic signed [VEL_W-1:0] r_out_ang;
    logic [SPEED_W-1:0]      r_out_speed;

    t_state r_state;
    t_state n_state;

    logic              w_in_ready;
    logic              w_in_fire;
    logic              w_out_fire;
    logic              w_emit;
    logic              w_cfg_fire;
    logic [NKEYS-1:0]  w_held;
    logic [TIME_W-1:0] w_elapsed [NKEYS];

    t_mul_req          w_req_lin;
    t_mul_req          w_req_ang;
    logic              w_lin_done;
    logic              w_ang_done;
    logic [PROD_W-1:0] w_prod_lin;
    logic [PROD_W-1:0] w_prod_ang;

    logic              w_fwd_up;
    logic              w_fwd_dn;
    logic              w_turn_lt;
    logic              w_turn_rt;

    logic [REM_W+1:0]  w_remx;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_out_fire = r_out_valid && o_out.ready;
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_out_valid;
    assign o_out.linear_velocity  = r_out_lin;
    assign o_out.angular_velocity = r_out_ang;
    assign o_out.speed            = r_out_speed;

    // ------------------------------------------------------------------
    // Hold test: a key counts as held when seen and pressed less than
    // HOLD_MS ago. The elapsed time wraps, so a press stamped in the
    // future looks old and is not held.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NKEYS; k++) begin
            w_elapsed[k] = r_now - r_press_time[k];
            w_held[k]    = r_press_seen[k] && (w_elapsed[k] < HOLD_MS);
        end
    end

    // opposite keys held together cancel: the axis then coasts on friction
    assign w_fwd_up  = r_held[KEY_UP] && !r_held[KEY_DOWN];
    assign w_fwd_dn  = r_held[KEY_DOWN] && !r_held[KEY_UP];
    assign w_turn_lt = r_held[KEY_LEFT] && !r_held[KEY_RIGHT];
    assign w_turn_rt = r_held[KEY_RIGHT] && !r_held[KEY_LEFT];

    // ------------------------------------------------------------------
    // Square root step: restoring, two radicand bits per cycle
    // ------------------------------------------------------------------
    assign w_remx  = {r_rem, r_rad[PROD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_remx >= w_trial);
    assign w_diff  = w_remx - w_trial;

    // ------------------------------------------------------------------
    // Multipliers: one lane per axis, run in lockstep. The same lane
    // serves brake gain, friction gain and the squares for speed.
    // ------------------------------------------------------------------
    khvr_mul u_mul_lin (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req_lin),
        .o_done    (w_lin_done),
        .o_product (w_prod_lin)
    );

    khvr_mul u_mul_ang (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req_ang),
        .o_done    (w_ang_done),
        .o_product (w_prod_ang)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && i_in.action) n_state = S_HELD;
            end
            S_HELD: begin
                n_state = w_held[KEY_BRAKE] ? S_BRAKE : S_FRIC;
            end
            S_BRAKE:      n_state = S_BRAKE_WAIT;
            S_BRAKE_WAIT: begin
                if (w_lin_done) n_state = S_FRIC;
            end
            S_FRIC:       n_state = S_FRIC_WAIT;
            S_FRIC_WAIT: begin
                if (w_lin_done) n_state = S_SQ;
            end
            S_SQ:         n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (w_lin_done) n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (input ready, multiplier launches)
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready      = (r_state == S_IDLE);
        w_req_lin.start = 1'b0;
        w_req_lin.mag   = vel_mag(r_lin);
        w_req_lin.mult  = vel_mag(r_lin);
        w_req_ang.start = 1'b0;
        w_req_ang.mag   = vel_mag(r_ang);
        w_req_ang.mult  = vel_mag(r_ang);
        unique case (r_state)
            S_BRAKE: begin
                w_req_lin.start = 1'b1;
                w_req_lin.mult  = r_brk_lin;
                w_req_ang.start = 1'b1;
                w_req_ang.mult  = r_brk_ang;
            end
            S_FRIC: begin
                w_req_lin.start = 1'b1;
                w_req_lin.mult  = r_fric_lin;
                w_req_ang.start = 1'b1;
                w_req_ang.mult  = r_fric_ang;
            end
            S_SQ: begin
                // multiplier operand already set to the magnitude: square
                w_req_lin.start = 1'b1;
                w_req_ang.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Control state: registers, seen bits, velocities, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_step   <= RST_LINEAR_STEP;
            r_ang_step   <= RST_ANGULAR_STEP;
            r_brk_lin    <= RST_BRAKE_LINEAR;
            r_brk_ang    <= RST_BRAKE_ANGULAR;
            r_fric_lin   <= RST_FRIC_LINEAR;
            r_fric_ang   <= RST_FRIC_ANGULAR;
            r_lin_limit  <= RST_LINEAR_LIMIT;
            r_ang_limit  <= RST_ANGULAR_LIMIT;
            r_press_seen <= '0;
            r_lin        <= '0;
            r_ang        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // a new result may replace the one taken in the same cycle
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end

            // register writes; indexes past the list are dropped
            if (w_cfg_fire) begin
                unique case (i_cfg.index)
                    REG_LINEAR_STEP:       r_lin_step  <= i_cfg.data[STEP_W-1:0];
                    REG_ANGULAR_STEP:      r_ang_step  <= i_cfg.data[STEP_W-1:0];
                    REG_BRAKE_GAIN_LIN:    r_brk_lin   <= i_cfg.data;
                    REG_BRAKE_GAIN_ANG:    r_brk_ang   <= i_cfg.data;
                    REG_FRICTION_GAIN_LIN: r_fric_lin  <= i_cfg.data;
                    REG_FRICTION_GAIN_ANG: r_fric_ang  <= i_cfg.data;
                    REG_LINEAR_LIMIT:      r_lin_limit <= i_cfg.data[LIMIT_W-1:0];
                    REG_ANGULAR_LIMIT:     r_ang_limit <= i_cfg.data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    // unused key codes are ignored
                    if (w_in_fire && !i_in.action && (i_in.key < KEY_W'(NKEYS))) begin
                        r_press_seen[i_in.key] <= 1'b1;
                    end
                end
                S_BRAKE_WAIT: begin
                    if (w_lin_done) begin
                        r_lin <= gain_finish(r_lin[VEL_W-1], w_prod_lin);
                        r_ang <= gain_finish(r_ang[VEL_W-1], w_prod_ang);
                    end
                end
                S_FRIC_WAIT: begin
                    // friction ran on both axes; keep it only where no key drives
                    if (w_lin_done) begin
                        r_lin <= (w_fwd_up || w_fwd_dn)
                               ? accel_clamp(r_lin, w_fwd_up, r_lin_step, r_lin_limit)
                               : gain_finish(r_lin[VEL_W-1], w_prod_lin);
                        r_ang <= (w_turn_lt || w_turn_rt)
                               ? accel_clamp(r_ang, w_turn_lt, r_ang_step, r_ang_limit)
                               : gain_finish(r_ang[VEL_W-1], w_prod_ang);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload: press stamps, hold flags, root unit, result beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_now <= i_in.time_ms;
                    if (!i_in.action && (i_in.key < KEY_W'(NKEYS))) begin
                        r_press_time[i_in.key] <= i_in.time_ms;
                    end
                end
            end
            S_HELD: begin
                r_held <= w_held;
            end
            S_SQ_WAIT: begin
                // lin^2 + ang^2 is at most 2^31, no carry out
                if (w_lin_done) begin
                    r_rad  <= w_prod_lin + w_prod_ang;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
            end
            S_ROOT: begin
                r_rad <= {r_rad[PROD_W-3:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
                if (w_ge) begin
                    r_rem  <= w_diff[REM_W-1:0];
                    r_root <= {r_root[SPEED_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_remx[REM_W-1:0];
                    r_root <= {r_root[SPEED_W-2:0], 1'b0};
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    r_out_lin   <= r_lin;
                    r_out_ang   <= r_ang;
                    r_out_speed <= r_root;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // both multiplier lanes are launched together and must finish together
    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lin_done == w_ang_done)
        else $error("multiplier lanes out of step");

    // a result beat is only raised from the emit state
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result beat raised outside emit");

    // a brake press marks the brake key as seen
    a_brake_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !i_in.action && (i_in.key == KEY_BRAKE)) |=> r_press_seen[KEY_BRAKE])
        else $error("brake press not recorded");

endmodule

`default_nettype wire

[tb/tb_key_hold_velocity_ramp_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_key_hold_velocity_ramp_unit: self-checking bench for the key-hold ramp
// Sends key press and control update beats and programs the gain, step and
// limit registers between phases. Both sides idle at random. A scoreboard
// class tracks key times and both velocities, predicts every update and
// compares the result beats in order.
// ============================================================================

module tb_key_hold_velocity_ramp_unit;
    import khvr_pkg::*;

    // Behavior constants of the ramp
    localparam int HOLD_WINDOW = 200;   // ms a press keeps its key held
    localparam int DEAD_ZONE   = 4;     // |v| below this snaps to zero

    // Bench timing
    localparam int SETTLE_CYCLES   = 60;    // margin after the last result, longer than the slowest update
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the block
    localparam int MAX_REPORTS     = 10;

    // Input beat kinds and codes the block must ignore
    localparam logic                 ACT_PRESS       = 1'b0;
    localparam logic                 ACT_UPDATE      = 1'b1;
    localparam logic [KEY_W-1:0]     KEY_SPARE_FIRST = 3'd5;
    localparam logic [KEY_W-1:0]     KEY_SPARE_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

    typedef struct packed {
        logic signed [VEL_W-1:0] lin;
        logic signed [VEL_W-1:0] ang;
        logic [SPEED_W-1:0]      speed;
    } t_ramp_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: key history, velocity state, registers, pending results
    // ------------------------------------------------------------------------
    class velocity_ramp_checker;
        logic [STEP_W-1:0]  lin_step, ang_step;
        logic [GAIN_W-1:0]  brake_lin, brake_ang, fric_lin, fric_ang;
        logic [LIMIT_W-1:0] lin_lim, ang_lim;
        logic [TIME_W-1:0]  press_at [NKEYS];
        logic [NKEYS-1:0]   seen;
        int                 lin_v, ang_v;
        t_ramp_beat         want_beats [$];
        int                 errors;

        function new();
            lin_step  = RST_LINEAR_STEP;
            ang_step  = RST_ANGULAR_STEP;
            brake_lin = RST_BRAKE_LINEAR;
            brake_ang = RST_BRAKE_ANGULAR;
            fric_lin  = RST_FRIC_LINEAR;
            fric_ang  = RST_FRIC_ANGULAR;
            lin_lim   = RST_LINEAR_LIMIT;
            ang_lim   = RST_ANGULAR_LIMIT;
            foreach (press_at[k]) press_at[k] = '0;
            seen   = '0;
            lin_v  = 0;
            ang_v  = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LINEAR_STEP:       lin_step  = data[STEP_W-1:0];
                REG_ANGULAR_STEP:      ang_step  = data[STEP_W-1:0];
                REG_BRAKE_GAIN_LIN:    brake_lin = data[GAIN_W-1:0];
                REG_BRAKE_GAIN_ANG:    brake_ang = data[GAIN_W-1:0];
                REG_FRICTION_GAIN_LIN: fric_lin  = data[GAIN_W-1:0];
                REG_FRICTION_GAIN_ANG: fric_ang  = data[GAIN_W-1:0];
                REG_LINEAR_LIMIT:      lin_lim   = data[LIMIT_W-1:0];
                REG_ANGULAR_LIMIT:     ang_lim   = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Elapsed time wraps mod 2^32, so a press in the future reads as old
        function bit held(int k, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gone;
            gone = now - press_at[k];
            return seen[k] && (gone < 32'(HOLD_WINDOW));
        endfunction

        // Q1.15 gain on the magnitude, round half away from zero, saturate
        function int gain_scale(int v, int g);
            longint mag, p;
            mag = (v < 0) ? -longint'(v) : longint'(v);
            p   = (mag * longint'(g) + 64'sd16384) >>> 15;
            if (v < 0) return (p > 32768) ? -32768 : -int'(p);
            return (p > 32767) ? 32767 : int'(p);
        endfunction

        function int dead_zone(int v);
            return (v > -DEAD_ZONE && v < DEAD_ZONE) ? 0 : v;
        endfunction

        function int axis_step(int v, int dir, int step, int lim, int gain);
            if (dir == 0) return dead_zone(gain_scale(v, gain));
            v = v + dir * step;
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return v;
        endfunction

        function logic [SPEED_W-1:0] root(longint x);
            longint r, t;
            r = 0;
            for (int b = SPEED_W - 1; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= x) r = t;
            end
            return r[SPEED_W-1:0];
        endfunction

        function void note_item(logic action, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
            t_ramp_beat b;
            int         fwd, turn;
            fwd  = 0;
            turn = 0;
            if (action == ACT_PRESS) begin
                if (key < NKEYS) begin
                    press_at[key] = now;
                    seen[key]     = 1'b1;
                end
                return;
            end
            if (held(KEY_BRAKE, now)) begin
                lin_v = dead_zone(gain_scale(lin_v, int'(brake_lin)));
                ang_v = dead_zone(gain_scale(ang_v, int'(brake_ang)));
            end
            if (held(KEY_UP, now))    fwd++;
            if (held(KEY_DOWN, now))  fwd--;
            if (held(KEY_LEFT, now))  turn++;
            if (held(KEY_RIGHT, now)) turn--;
            lin_v   = axis_step(lin_v, fwd, int'(lin_step), int'(lin_lim), int'(fric_lin));
            ang_v   = axis_step(ang_v, turn, int'(ang_step), int'(ang_lim), int'(fric_ang));
            b.lin   = lin_v[VEL_W-1:0];
            b.ang   = ang_v[VEL_W-1:0];
            b.speed = root(longint'(lin_v) * lin_v + longint'(ang_v) * ang_v);
            want_beats.push_back(b);
        endfunction

        function void check_beat(t_ramp_beat got);
            t_ramp_beat w;
            if (want_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: lin %0d ang %0d speed %0d",
                             got.lin, got.ang, got.speed);
                return;
            end
            w = want_beats.pop_front();
            if (got.lin !== w.lin || got.ang !== w.ang || got.speed !== w.speed) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"result mismatch: lin exp %0d got %0d, ",
                              "ang exp %0d got %0d, speed exp %0d got %0d"},
                             w.lin, got.lin, w.ang, got.ang, w.speed, got.speed);
            end
        endfunction

        function int pending();
            return want_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    khvr_in_if  in_ch ();
    khvr_out_if out_ch ();
    khvr_cfg_if cfg_ch ();

    key_hold_velocity_ramp_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    velocity_ramp_checker ramp_chk;
    t_ramp_beat           out_beat;
    bit                   steady;      // no idling on either side while set
    bit                   hold_req;    // ask the receiver for one long stall
    logic [TIME_W-1:0]    now_ms;      // running millisecond clock of the stimulus
    int unsigned          phase_vals [8];

    // Short gaps mostly, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic int input_gap();
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: every handshake is seen at the rising edge. Results are checked
    // before the input of the same edge is noted; they cannot be related.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                out_beat = {out_ch.linear_velocity, out_ch.angular_velocity, out_ch.speed};
                ramp_chk.check_beat(out_beat);
            end
            if (in_ch.valid && in_ch.ready)
                ramp_chk.note_item(in_ch.action, in_ch.key, in_ch.time_ms);
            if (cfg_ch.valid && cfg_ch.ready)
                ramp_chk.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : out_ready_gen
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_req   = 1'b0;
                stall_left = 0;
            end else if (stall_left > 0 && !steady) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = 0;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: change at the falling edge, handshake seen at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic a, input logic [KEY_W-1:0] k,
                             input logic [TIME_W-1:0] t, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.action  <= a;
        in_ch.key     <= k;
        in_ch.time_ms <= t;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain: every result in, then a margin since a press leaves no trace
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (ramp_chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < 8; i++)
            cfg_write(CFG_IDX_W'(i), CFG_DATA_W'(phase_vals[i]));
        // a write past the last register must leave everything alone
        cfg_write(CFG_IDX_W'($urandom_range(8, 255)), CFG_DATA_W'($urandom()));
    endtask

    // Mostly presses and updates close in time so keys stay held; now and then
    // keys expire, the clock jumps anywhere, or a press lands in the future.
    task automatic random_run(input int n);
        logic              a;
        logic [KEY_W-1:0]  k;
        logic [TIME_W-1:0] t;
        int                r;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3)      now_ms = $urandom();
            else if (r < 8) now_ms = now_ms + $urandom_range(200, 5000);
            else            now_ms = now_ms + $urandom_range(0, 60);
            if ($urandom_range(0, 99) < 35) begin
                a = ACT_PRESS;
                if ($urandom_range(0, 19) == 0)
                    k = KEY_W'($urandom_range(KEY_SPARE_FIRST, KEY_SPARE_LAST));
                else
                    k = KEY_W'($urandom_range(KEY_UP, KEY_BRAKE));
            end else begin
                a = ACT_UPDATE;
                k = KEY_W'($urandom_range(0, 7));   // key field is don't-care on update
            end
            t = now_ms;
            if (a == ACT_PRESS && $urandom_range(0, 29) == 0) t = now_ms + $urandom_range(1, 1000);
            send_item(a, k, t, input_gap());
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        ramp_chk      = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.action  = 1'b0;
        in_ch.key     = '0;
        in_ch.time_ms = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        now_ms        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset register values ---
        // press times are not reset, but no key counts as seen yet
        send_item(ACT_UPDATE, KEY_UP, 32'd50, input_gap());
        send_item(ACT_PRESS, KEY_SPARE_LAST, 32'd60, input_gap());
        send_item(ACT_PRESS, KEY_SPARE_FIRST, 32'd61, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd70, input_gap());
        // hold window edges: 0 and 199 ms held, 200 ms released
        send_item(ACT_PRESS, KEY_UP, 32'd1000, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd1000, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd1199, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd1200, input_gap());
        // both keys of an axis held cancel out
        send_item(ACT_PRESS, KEY_LEFT, 32'd2000, input_gap());
        send_item(ACT_PRESS, KEY_UP, 32'd2000, input_gap());
        send_item(ACT_PRESS, KEY_DOWN, 32'd2010, input_gap());
        send_item(ACT_PRESS, KEY_RIGHT, 32'd2010, input_gap());
        send_item(ACT_UPDATE, KEY_BRAKE, 32'd2020, input_gap());
        send_item(ACT_PRESS, KEY_BRAKE, 32'd3000, input_gap());
        send_item(ACT_UPDATE, KEY_BRAKE, 32'd3010, input_gap());
        // press stamped in the future counts as long ago
        send_item(ACT_PRESS, KEY_UP, 32'd9000, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd8000, input_gap());
        // hold spans the 32-bit wrap of the ms clock
        send_item(ACT_PRESS, KEY_LEFT, 32'hFFFF_FFC0, input_gap());
        send_item(ACT_UPDATE, KEY_LEFT, 32'h0000_0040, input_gap());

        // --- directed, every register at its top; gains above one saturate ---
        settle();
        foreach (phase_vals[i]) phase_vals[i] = 32'h0000_FFFF;
        for (int i = 0; i < 8; i++)
            cfg_write(CFG_IDX_W'(i), CFG_DATA_W'(phase_vals[i]));
        // data that would show up if the spare index aliased onto a register
        cfg_write(REG_SPARE_LAST, 16'h0001);
        cfg_write(REG_SPARE_FIRST, 16'h0003);
        send_item(ACT_PRESS, KEY_UP, 32'd5000, input_gap());
        send_item(ACT_PRESS, KEY_RIGHT, 32'd5000, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd5001, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd5002, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd5400, input_gap());
        send_item(ACT_PRESS, KEY_BRAKE, 32'd5401, input_gap());
        send_item(ACT_PRESS, KEY_DOWN, 32'd5401, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd5402, input_gap());
        // lowered limits only bite on an axis that accelerates
        settle();
        cfg_write(REG_LINEAR_LIMIT, 16'd1000);
        cfg_write(REG_ANGULAR_LIMIT, 16'd0);
        send_item(ACT_UPDATE, KEY_UP, 32'd5700, input_gap());
        send_item(ACT_PRESS, KEY_UP, 32'd5701, input_gap());
        send_item(ACT_PRESS, KEY_LEFT, 32'd5701, input_gap());
        send_item(ACT_UPDATE, KEY_UP, 32'd5702, input_gap());
        now_ms = 32'd6000;

        // --- random phases, one register setting each ---
        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: begin
                    phase_vals[0] = 32'(RST_LINEAR_STEP);
                    phase_vals[1] = 32'(RST_ANGULAR_STEP);
                    phase_vals[2] = 32'(RST_BRAKE_LINEAR);
                    phase_vals[3] = 32'(RST_BRAKE_ANGULAR);
                    phase_vals[4] = 32'(RST_FRIC_LINEAR);
                    phase_vals[5] = 32'(RST_FRIC_ANGULAR);
                    phase_vals[6] = 32'(RST_LINEAR_LIMIT);
                    phase_vals[7] = 32'(RST_ANGULAR_LIMIT);
                end
                2: foreach (phase_vals[i]) phase_vals[i] = 0;
                3: begin
                    // big steps against small limits
                    phase_vals[0] = $urandom_range(4096, 16383);
                    phase_vals[1] = $urandom_range(4096, 16383);
                    for (int i = 2; i < 6; i++) phase_vals[i] = $urandom_range(0, 32768);
                    phase_vals[6] = $urandom_range(0, 2047);
                    phase_vals[7] = $urandom_range(0, 2047);
                end
                4: begin
                    // slow ramp, light friction, strong brake
                    phase_vals[0] = $urandom_range(0, 1024);
                    phase_vals[1] = $urandom_range(0, 1024);
                    phase_vals[2] = $urandom_range(0, 8000);
                    phase_vals[3] = $urandom_range(0, 8000);
                    phase_vals[4] = $urandom_range(30000, 32768);
                    phase_vals[5] = $urandom_range(30000, 32768);
                    phase_vals[6] = $urandom_range(4096, 32767);
                    phase_vals[7] = $urandom_range(4096, 32767);
                end
                default: foreach (phase_vals[i]) phase_vals[i] = $urandom_range(0, 65535);
            endcase
            program_regs();
            // one long receiver stall while updates keep coming
            if (p == 1) hold_req = 1'b1;
            case (p)
                0:       random_run(120);
                2:       random_run(60);
                4:       random_run(110);
                default: random_run(100);
            endcase
        end

        settle();
        if (ramp_chk.errors == 0 && ramp_chk.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin : watchdog
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[key_hold_velocity_ramp_unit.f]
sv/khvr_pkg.sv
sv/khvr_if.sv
sv/khvr_mul.sv
sv/key_hold_velocity_ramp_unit.sv
tb/tb_key_hold_velocity_ramp_unit.sv
